/* sv/dcg_pkg.sv */
package dcg_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 9;
  localparam int unsigned IdxW  = 5;

  // tdata widths, padded to whole bytes
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 104;

  localparam int unsigned DefPinCount = 32;

  localparam logic [AddrW-1:0] OfsDataOne = 9'h000;
  localparam logic [AddrW-1:0] OfsDirOne  = 9'h004;
  localparam logic [AddrW-1:0] OfsDataTwo = 9'h008;
  localparam logic [AddrW-1:0] OfsDirTwo  = 9'h00C;
  localparam logic [AddrW-1:0] OfsGlobal  = 9'h11C;
  localparam logic [AddrW-1:0] OfsStatus  = 9'h120;
  localparam logic [AddrW-1:0] OfsEnable  = 9'h128;

  localparam int unsigned GlobalBit = 31;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_PIN   = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e            mode;
    logic [AddrW-1:0] reg_addr;
    logic [DataW-1:0] write_data;
    logic             pin_channel;
    logic [IdxW-1:0]  pin_index;
    logic             pin_level;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             irq_out;
    logic [DataW-1:0] drive_one;
    logic [DataW-1:0] drive_two;
  } result_t;

endpackage

/* sv/dcg_core.sv */
module dcg_core #(
  parameter int unsigned PIN_COUNT = dcg_pkg::DefPinCount
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  dcg_pkg::item_t  item_i,
  output dcg_pkg::result_t result_o
);

  localparam logic [dcg_pkg::DataW-1:0] PinMask =
    dcg_pkg::DataW'((64'd1 << PIN_COUNT) - 64'd1);

  logic [dcg_pkg::DataW-1:0] data_one_q, data_one_d, dir_one_q, dir_one_d;
  logic [dcg_pkg::DataW-1:0] data_two_q, data_two_d, dir_two_q, dir_two_d;
  logic [dcg_pkg::DataW-1:0] gie_q, gie_d, status_q, status_d, enable_q, enable_d;
  logic [dcg_pkg::DataW-1:0] pins_one_q, pins_one_d, pins_two_q, pins_two_d;

  logic [dcg_pkg::DataW-1:0] rdata;
  logic [dcg_pkg::DataW-1:0] sel_one, sel_two, cur_data, cur_dir, bit_mask;
  logic                      idx_ok, pin_hit;

  assign sel_one  = ~dir_one_q & PinMask;
  assign sel_two  = ~dir_two_q & PinMask;
  assign cur_data = item_i.pin_channel ? data_two_q : data_one_q;
  assign cur_dir  = item_i.pin_channel ? dir_two_q : dir_one_q;
  assign bit_mask = dcg_pkg::DataW'(1) << item_i.pin_index;
  assign idx_ok   = {1'b0, item_i.pin_index} < 6'(PIN_COUNT);
  // counts only for an input pin whose level really changes
  assign pin_hit  = idx_ok && cur_dir[item_i.pin_index]
                    && (cur_data[item_i.pin_index] != item_i.pin_level);

  always_comb begin
    data_one_d = data_one_q;
    dir_one_d  = dir_one_q;
    data_two_d = data_two_q;
    dir_two_d  = dir_two_q;
    gie_d      = gie_q;
    status_d   = status_q;
    enable_d   = enable_q;
    pins_one_d = pins_one_q;
    pins_two_d = pins_two_q;
    rdata      = '0;
    case (item_i.mode)
      dcg_pkg::MODE_READ: begin
        unique case (item_i.reg_addr)
          dcg_pkg::OfsDataOne: rdata = data_one_q;
          dcg_pkg::OfsDirOne:  rdata = dir_one_q;
          dcg_pkg::OfsDataTwo: rdata = data_two_q;
          dcg_pkg::OfsDirTwo:  rdata = dir_two_q;
          dcg_pkg::OfsGlobal:  rdata = gie_q;
          dcg_pkg::OfsStatus:  rdata = status_q;
          dcg_pkg::OfsEnable:  rdata = enable_q;
          default:             rdata = '1;
        endcase
      end
      dcg_pkg::MODE_WRITE: begin
        unique case (item_i.reg_addr)
          dcg_pkg::OfsDataOne: begin
            data_one_d = item_i.write_data;
            pins_one_d = (pins_one_q & ~sel_one) | (item_i.write_data & sel_one);
          end
          dcg_pkg::OfsDirOne:  dir_one_d = item_i.write_data;
          dcg_pkg::OfsDataTwo: begin
            data_two_d = item_i.write_data;
            pins_two_d = (pins_two_q & ~sel_two) | (item_i.write_data & sel_two);
          end
          dcg_pkg::OfsDirTwo:  dir_two_d = item_i.write_data;
          dcg_pkg::OfsGlobal:  gie_d     = item_i.write_data;
          dcg_pkg::OfsStatus:  status_d  = item_i.write_data;
          dcg_pkg::OfsEnable:  enable_d  = item_i.write_data;
          default: ;
        endcase
      end
      dcg_pkg::MODE_PIN: begin
        if (pin_hit) begin
          if (item_i.pin_channel) begin
            data_two_d  = item_i.pin_level ? (data_two_q | bit_mask)
                                           : (data_two_q & ~bit_mask);
            status_d[1] = 1'b1;
          end else begin
            data_one_d  = item_i.pin_level ? (data_one_q | bit_mask)
                                           : (data_one_q & ~bit_mask);
            status_d[0] = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign result_o.read_data = rdata;
  assign result_o.irq_out   = gie_d[dcg_pkg::GlobalBit] && ((status_d & enable_d) != '0);
  assign result_o.drive_one = pins_one_d;
  assign result_o.drive_two = pins_two_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_one_q <= '0;
      dir_one_q  <= '0;
      data_two_q <= '0;
      dir_two_q  <= '0;
      gie_q      <= '0;
      status_q   <= '0;
      enable_q   <= '0;
      pins_one_q <= '0;
      pins_two_q <= '0;
    end else if (step_i) begin
      data_one_q <= data_one_d;
      dir_one_q  <= dir_one_d;
      data_two_q <= data_two_d;
      dir_two_q  <= dir_two_d;
      gie_q      <= gie_d;
      status_q   <= status_d;
      enable_q   <= enable_d;
      pins_one_q <= pins_one_d;
      pins_two_q <= pins_two_d;
    end
  end

endmodule

/* sv/dual_channel_gpio_with_interrupt.sv */
// Path: an input word is held in the input register, then its result word
//   in the result register.
// Throughput: one word per cycle while m_tready_i does not stall the output;
//   the register-file update and decode sit between the two registers.
// Reset (rst_ni low, asynchronous): all GPIO registers and pin levels
//   clear to zero (every pin an output), both stages empty.
module dual_channel_gpio_with_interrupt #(
  parameter int unsigned PIN_COUNT = dcg_pkg::DefPinCount
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  // [8:0] reg_addr, [40:9] write_data, [41] pin_channel, [46:42] pin_index,
  // [47] pin_level
  input  logic [dcg_pkg::InDataW-1:0]  s_tdata_i,
  // [1:0] mode
  input  logic [1:0]                   s_tuser_i,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  // [31:0] read_data, [32] irq_out, [64:33] drive_one, [96:65] drive_two,
  // [103:97] zero
  output logic [dcg_pkg::OutDataW-1:0] m_tdata_o
);

  dcg_pkg::item_t   item_q, item_d;
  dcg_pkg::result_t res_q, res_d;
  logic             in_valid_q, out_valid_q;
  logic             step, s_acc;

  assign step       = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || step;
  assign s_acc      = s_tvalid_i && s_tready_o;

  always_comb begin
    item_d.mode        = dcg_pkg::mode_e'(s_tuser_i);
    item_d.reg_addr    = s_tdata_i[8:0];
    item_d.write_data  = s_tdata_i[40:9];
    item_d.pin_channel = s_tdata_i[41];
    item_d.pin_index   = s_tdata_i[46:42];
    item_d.pin_level   = s_tdata_i[47];
  end

  dcg_core #(
    .PIN_COUNT(PIN_COUNT)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item_q),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      item_q <= item_d;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {7'd0, res_q.drive_two, res_q.drive_one, res_q.irq_out,
                       res_q.read_data};

endmodule

/* verif/gpio_checker.sv */
module gpio_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  // [8:0] reg_addr, [40:9] write_data, [41] pin_channel, [46:42] pin_index,
  // [47] pin_level
  input  logic [dcg_pkg::InDataW-1:0]  s_tdata_i,
  // [1:0] mode
  input  logic [1:0]                   s_tuser_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  // [31:0] read_data, [32] irq_out, [64:33] drive_one, [96:65] drive_two
  input  logic [dcg_pkg::OutDataW-1:0] m_tdata_i,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dcg_pkg::DataW-1:0] PinMask =
      (dcg_pkg::DefPinCount >= dcg_pkg::DataW) ? '1 :
      dcg_pkg::DataW'((64'd1 << dcg_pkg::DefPinCount) - 64'd1);

  // shadow copy of the register file, indexed by channel
  logic [dcg_pkg::DataW-1:0] port_data [2];
  logic [dcg_pkg::DataW-1:0] port_dir  [2];
  logic [dcg_pkg::DataW-1:0] port_pins [2];
  logic [dcg_pkg::DataW-1:0] irq_global;
  logic [dcg_pkg::DataW-1:0] irq_status;
  logic [dcg_pkg::DataW-1:0] irq_enable;

  dcg_pkg::result_t expected_results [$];
  dcg_pkg::item_t   in_word;
  dcg_pkg::result_t want;
  dcg_pkg::result_t got;
  int unsigned      errs;

  function automatic dcg_pkg::result_t advance_gpio(dcg_pkg::item_t w);
    dcg_pkg::result_t          r;
    logic [dcg_pkg::DataW-1:0] sel;
    logic [dcg_pkg::DataW-1:0] bit_mask;
    logic                      ch;
    r = '0;
    case (w.mode)
      dcg_pkg::MODE_READ: begin
        case (w.reg_addr)
          dcg_pkg::OfsDataOne: r.read_data = port_data[0];
          dcg_pkg::OfsDirOne:  r.read_data = port_dir[0];
          dcg_pkg::OfsDataTwo: r.read_data = port_data[1];
          dcg_pkg::OfsDirTwo:  r.read_data = port_dir[1];
          dcg_pkg::OfsGlobal:  r.read_data = irq_global;
          dcg_pkg::OfsStatus:  r.read_data = irq_status;
          dcg_pkg::OfsEnable:  r.read_data = irq_enable;
          default:             r.read_data = '1;
        endcase
      end
      dcg_pkg::MODE_WRITE: begin
        case (w.reg_addr)
          dcg_pkg::OfsDataOne, dcg_pkg::OfsDataTwo: begin
            ch = (w.reg_addr == dcg_pkg::OfsDataTwo);
            port_data[ch] = w.write_data;
            // only pins configured as outputs take the new level
            sel = ~port_dir[ch] & PinMask;
            port_pins[ch] = (port_pins[ch] & ~sel) | (w.write_data & sel);
          end
          dcg_pkg::OfsDirOne, dcg_pkg::OfsDirTwo: begin
            ch = (w.reg_addr == dcg_pkg::OfsDirTwo);
            port_dir[ch] = w.write_data;
          end
          dcg_pkg::OfsGlobal: irq_global = w.write_data;
          dcg_pkg::OfsStatus: irq_status = w.write_data;
          dcg_pkg::OfsEnable: irq_enable = w.write_data;
          default: ;
        endcase
      end
      dcg_pkg::MODE_PIN: begin
        ch = w.pin_channel;
        if (w.pin_index < dcg_pkg::DefPinCount) begin
          bit_mask = dcg_pkg::DataW'(1) << w.pin_index;
          if ((port_dir[ch] & bit_mask) != '0 &&
              ((port_data[ch] & bit_mask) != '0) != w.pin_level) begin
            port_data[ch] = port_data[ch] ^ bit_mask;
            irq_status = irq_status | (ch ? dcg_pkg::DataW'(2) : dcg_pkg::DataW'(1));
          end
        end
      end
      default: ;
    endcase
    r.irq_out   = irq_global[dcg_pkg::GlobalBit] & (|(irq_status & irq_enable));
    r.drive_one = port_pins[0];
    r.drive_two = port_pins[1];
    return r;
  endfunction

  task automatic check_field(string name, logic [dcg_pkg::DataW-1:0] exp_v,
                             logic [dcg_pkg::DataW-1:0] act_v);
    if (exp_v !== act_v) begin
      errs++;
      if (errs <= 10) begin
        $display("%0t gpio_checker: %s mismatch, expected %h got %h", $realtime, name, exp_v,
                 act_v);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        port_data[c] = '0;
        port_dir[c]  = '0;
        port_pins[c] = '0;
      end
      irq_global = '0;
      irq_status = '0;
      irq_enable = '0;
      expected_results.delete();
      errs = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      // result side first: a word accepted now can't belong to this edge's input
      if (m_tvalid_i && m_tready_i) begin
        got.read_data = m_tdata_i[31:0];
        got.irq_out   = m_tdata_i[32];
        got.drive_one = m_tdata_i[64:33];
        got.drive_two = m_tdata_i[96:65];
        if (expected_results.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("%0t gpio_checker: unexpected result word %h", $realtime, m_tdata_i);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("irq_out", dcg_pkg::DataW'(want.irq_out), dcg_pkg::DataW'(got.irq_out));
          check_field("drive_one", want.drive_one, got.drive_one);
          check_field("drive_two", want.drive_two, got.drive_two);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        in_word.mode        = dcg_pkg::mode_e'(s_tuser_i);
        in_word.reg_addr    = s_tdata_i[8:0];
        in_word.write_data  = s_tdata_i[40:9];
        in_word.pin_channel = s_tdata_i[41];
        in_word.pin_index   = s_tdata_i[46:42];
        in_word.pin_level   = s_tdata_i[47];
        expected_results.push_back(advance_gpio(in_word));
      end
      pending_o <= expected_results.size();
      mismatch_count_o <= errs;
    end
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomWords = 1200;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned IdleLimit = 2000;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [dcg_pkg::InDataW-1:0]  s_tdata;
  logic [1:0]                   s_tuser;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [dcg_pkg::OutDataW-1:0] m_tdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned burst_left;
  bit          hold_off_req;
  bit          hold_off_done;

  logic [dcg_pkg::AddrW-1:0] mapped_ofs [7] = '{
    dcg_pkg::OfsDataOne, dcg_pkg::OfsDirOne, dcg_pkg::OfsDataTwo, dcg_pkg::OfsDirTwo,
    dcg_pkg::OfsGlobal, dcg_pkg::OfsStatus, dcg_pkg::OfsEnable};

  always #5 clk = ~clk;

  dual_channel_gpio_with_interrupt dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata)
  );

  gpio_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .s_tuser_i        (s_tuser),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(dcg_pkg::mode_e m, logic [dcg_pkg::AddrW-1:0] addr,
                           logic [dcg_pkg::DataW-1:0] wdata, logic ch,
                           logic [dcg_pkg::IdxW-1:0] idx, logic lvl);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {lvl, idx, ch, wdata, addr};
    s_tuser  <= m;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    burst_left = 0;
  endtask

  // result side: switches among random stall styles, with one long hold-off on request
  initial begin
    int unsigned tick;
    int unsigned style;
    tick = 0;
    style = 0;
    hold_off_done = 1'b0;
    m_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 64 == 0) style = $urandom_range(0, 3);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
      end else begin
        case (style)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom);
          2:       m_tready <= (tick % 3 == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    int unsigned               roll;
    dcg_pkg::mode_e            m;
    logic [dcg_pkg::AddrW-1:0] addr;
    logic [dcg_pkg::DataW-1:0] wdata;
    rst_n = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    hold_off_req = 1'b0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_word(dcg_pkg::MODE_READ,  dcg_pkg::OfsDataOne, '0, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_WRITE, dcg_pkg::OfsDirOne, 32'hFFFF_0000, 1'b0, 5'd0, 1'b0);
    // upper half is input: stored but not driven
    send_word(dcg_pkg::MODE_WRITE, dcg_pkg::OfsDataOne, '1, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_READ,  dcg_pkg::OfsDataOne, '0, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_PIN,   '0, '0, 1'b0, 5'd31, 1'b0);
    // same level again, then a pin that is an output: both ignored
    send_word(dcg_pkg::MODE_PIN,   '0, '0, 1'b0, 5'd31, 1'b0);
    send_word(dcg_pkg::MODE_PIN,   '0, '0, 1'b0, 5'd0, 1'b1);
    send_word(dcg_pkg::MODE_WRITE, dcg_pkg::OfsEnable, '1, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_WRITE, dcg_pkg::OfsGlobal, 32'h8000_0000, 1'b0, 5'd0, 1'b0);
    // status is a plain store, not write-one-to-clear
    send_word(dcg_pkg::MODE_WRITE, dcg_pkg::OfsStatus, '0, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_WRITE, dcg_pkg::OfsStatus, 32'h1234_5678, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_READ,  dcg_pkg::OfsStatus, '0, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_WRITE, dcg_pkg::OfsGlobal, 32'h7FFF_FFFF, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_READ,  dcg_pkg::OfsGlobal, '0, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_WRITE, dcg_pkg::OfsDirTwo, '1, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_WRITE, dcg_pkg::OfsDataTwo, 32'hA5A5_A5A5, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_PIN,   '0, '0, 1'b1, 5'd31, 1'b0);
    send_word(dcg_pkg::MODE_READ,  dcg_pkg::OfsDataTwo, '0, 1'b0, 5'd0, 1'b0);
    // unmapped and unaligned offsets
    send_word(dcg_pkg::MODE_READ,  9'h1FF, '0, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_READ,  9'h001, '0, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_WRITE, 9'h010, '1, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_READ,  9'h010, '0, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_NOP,   9'h1FF, '1, 1'b1, 5'd31, 1'b1);
    send_word(dcg_pkg::MODE_WRITE, dcg_pkg::OfsDirTwo, '0, 1'b0, 5'd0, 1'b0);
    send_word(dcg_pkg::MODE_WRITE, dcg_pkg::OfsDataTwo, 32'h5A5A_5A5A, 1'b0, 5'd0, 1'b0);
    wait_drained();

    for (int unsigned n = 0; n < RandomWords; n++) begin
      if (n == 40) hold_off_req = 1'b1;
      if (n == RandomWords / 2) wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < 30) m = dcg_pkg::MODE_READ;
      else if (roll < 60) m = dcg_pkg::MODE_WRITE;
      else if (roll < 95) m = dcg_pkg::MODE_PIN;
      else m = dcg_pkg::MODE_NOP;
      if ($urandom_range(0, 99) < 85) addr = mapped_ofs[$urandom_range(0, 6)];
      else addr = dcg_pkg::AddrW'($urandom);
      case ($urandom_range(0, 7))
        0:       wdata = '0;
        1:       wdata = '1;
        2:       wdata = 32'h8000_0000;
        default: wdata = $urandom;
      endcase
      send_word(m, addr, wdata, 1'($urandom), dcg_pkg::IdxW'($urandom), 1'($urandom));
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
